>>> rtl/lru_tlb_pkg.sv
// ---------------------------------------------------------------------------
// lru_tlb_pkg: shared types and constants
// Operation codes, field widths and the front-to-back command record.
// ---------------------------------------------------------------------------
package lru_tlb_pkg;

  localparam int PageW  = 52;
  localparam int SpaceW = 8;
  localparam int CountW = 32;
  localparam int DefaultEntries = 16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PageW-1:0]  page;
    logic [SpaceW-1:0] space;
    logic [PageW-1:0]  fframe;
  } cmd_t;

endpackage

>>> rtl/lru_tlb_front.sv
// ---------------------------------------------------------------------------
// lru_tlb_front: input stage and command queue
// Accept beats, fold the space id to zero when ids are off, and queue them.
// ---------------------------------------------------------------------------
module lru_tlb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       asid_on,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lru_tlb_pkg::cmd_t          in_cmd,
  output logic                       q_valid,
  input  logic                       q_ready,
  output lru_tlb_pkg::cmd_t          q_cmd
);

  // two-entry queue
  lru_tlb_pkg::cmd_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  lru_tlb_pkg::cmd_t cls;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cls = in_cmd;
    if (!asid_on) begin
      cls.space = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/lru_tlb_back.sv
// ---------------------------------------------------------------------------
// lru_tlb_back: entry array, age order and counters
// Match when a command is taken; update and register the result in the next.
// ---------------------------------------------------------------------------
module lru_tlb_back #(
  parameter int ENTRIES = lru_tlb_pkg::DefaultEntries
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  lru_tlb_pkg::cmd_t                 q_cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [lru_tlb_pkg::PageW-1:0]     frame,
  output logic [lru_tlb_pkg::CountW-1:0]    lookup_count,
  output logic [lru_tlb_pkg::CountW-1:0]    hit_count,
  output logic [lru_tlb_pkg::CountW-1:0]    eviction_count,
  output logic [lru_tlb_pkg::CountW-1:0]    flush_count,
  output logic [lru_tlb_pkg::CountW-1:0]    flush_drop_count
);

  localparam int IdxW = $clog2(ENTRIES);
  localparam int AgeW = $clog2(ENTRIES);
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int CountW = lru_tlb_pkg::CountW;

  typedef enum logic {ST_MATCH, ST_UPDATE} state_t;
  state_t state;

  logic [ENTRIES-1:0]                 valid;
  logic [lru_tlb_pkg::PageW-1:0]      epage  [ENTRIES];
  logic [lru_tlb_pkg::PageW-1:0]      eframe [ENTRIES];
  logic [lru_tlb_pkg::SpaceW-1:0]     espace [ENTRIES];
  logic [AgeW-1:0]                    eage   [ENTRIES];

  lru_tlb_pkg::cmd_t   cmd;
  logic [ENTRIES-1:0]  page_eq;
  logic [ENTRIES-1:0]  full_eq;
  logic [ENTRIES-1:0]  page_eq_r;
  logic [ENTRIES-1:0]  full_eq_r;

  // match vectors are registered; the update cycle encodes them
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      page_eq[i] = valid[i] && (epage[i] == q_cmd.page);
      full_eq[i] = page_eq[i] && (espace[i] == q_cmd.space);
    end
  end

  logic             any_hit, any_same, any_free;
  logic [IdxW-1:0]  hit_idx, same_idx, free_idx, old_idx, k;
  logic [AgeW-1:0]  limit;
  logic             no_limit;
  logic [CntW-1:0]  nvalid;

  always_comb begin
    any_hit = 1'b0; any_same = 1'b0; any_free = 1'b0;
    hit_idx = '0; same_idx = '0; free_idx = '0; old_idx = '0;
    nvalid = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (full_eq_r[i]) begin any_hit = 1'b1; hit_idx = IdxW'(i); end
      if (page_eq_r[i]) begin any_same = 1'b1; same_idx = IdxW'(i); end
      if (!valid[i]) begin any_free = 1'b1; free_idx = IdxW'(i); end
    end
    // when full, the oldest entry has age ENTRIES-1
    for (int i = 0; i < ENTRIES; i++) begin
      if (eage[i] == AgeW'(ENTRIES - 1)) old_idx = IdxW'(i);
      nvalid = nvalid + CntW'(valid[i]);
    end
    if (any_same) begin
      k = same_idx; limit = eage[same_idx]; no_limit = 1'b0;
    end else if (any_free) begin
      k = free_idx; limit = '0; no_limit = 1'b1;
    end else begin
      k = old_idx; limit = '0; no_limit = 1'b1;
    end
  end

  // take the next command as the waiting result leaves
  assign q_ready = (state == ST_MATCH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (state == ST_MATCH && q_valid && q_ready) begin
      cmd       <= q_cmd;
      page_eq_r <= page_eq;
      full_eq_r <= full_eq;
    end
    if (state == ST_UPDATE) begin
      hit   <= 1'b0;
      frame <= '0;
      case (cmd.op)
        lru_tlb_pkg::OP_LOOKUP: begin
          if (any_hit) begin
            hit   <= 1'b1;
            frame <= eframe[hit_idx];
          end
        end
        lru_tlb_pkg::OP_FILL: begin
          epage[k]  <= cmd.page;
          eframe[k] <= cmd.fframe;
          espace[k] <= cmd.space;
        end
        default: ;
      endcase
    end
    if (rst) begin
      state            <= ST_MATCH;
      out_valid        <= 1'b0;
      valid            <= '0;
      lookup_count     <= '0;
      hit_count        <= '0;
      eviction_count   <= '0;
      flush_count      <= '0;
      flush_drop_count <= '0;
      for (int i = 0; i < ENTRIES; i++) eage[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_MATCH: begin
          if (q_valid && q_ready) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state     <= ST_MATCH;
          out_valid <= 1'b1;
          case (cmd.op)
            lru_tlb_pkg::OP_LOOKUP: begin
              lookup_count <= lookup_count + 1'b1;
              if (any_hit) hit_count <= hit_count + 1'b1;
            end
            lru_tlb_pkg::OP_FILL: begin
              if (!any_same && !any_free) eviction_count <= eviction_count + 1'b1;
              valid[k] <= 1'b1;
              for (int i = 0; i < ENTRIES; i++) begin
                if (IdxW'(i) == k) eage[i] <= '0;
                else if (valid[i] && (no_limit || eage[i] < limit))
                  eage[i] <= eage[i] + 1'b1;
              end
            end
            lru_tlb_pkg::OP_FLUSH: begin
              flush_count      <= flush_count + 1'b1;
              flush_drop_count <= flush_drop_count + CountW'(nvalid);
              valid            <= '0;
              for (int i = 0; i < ENTRIES; i++) eage[i] <= '0;
            end
            default: ;
          endcase
        end
        default: state <= ST_MATCH;
      endcase
    end
  end

endmodule

>>> rtl/lru_tlb_with_asid.sv
// ---------------------------------------------------------------------------
// lru_tlb_with_asid: fully associative TLB with LRU replacement and ids
// Top level: input queue in front, entry array and counters behind.
// ---------------------------------------------------------------------------
// Use:
//   One input beat (operation, virtual_page, space_id, fill_frame) on the
//   in_valid/in_ready channel gives exactly one result beat (hit, frame and
//   the five counters) on out_valid/out_ready, in order.
//   cfg_valid/cfg_ready writes asid_enable; write it only while idle.
// Processing:
//   The back end passes each item through a match state (parallel tag
//   compare over all entries) and an update state (index encode, age
//   update, counters), and takes no new item until the last one has
//   left the update state and its result register is free or draining.
// Stalls:
//   While a result waits, the back end holds; the two-deep front queue
//   keeps taking beats until full, then drops in_ready.
// Reset:
//   rst clears all valid bits, ages, counters and asid_enable. No clearing
//   pass is needed: entries are read only while valid.
// ---------------------------------------------------------------------------
module lru_tlb_with_asid #(
  parameter int ENTRIES = lru_tlb_pkg::DefaultEntries
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      operation,
  input  logic [lru_tlb_pkg::PageW-1:0]   virtual_page,
  input  logic [lru_tlb_pkg::SpaceW-1:0]  space_id,
  input  logic [lru_tlb_pkg::PageW-1:0]   fill_frame,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [lru_tlb_pkg::PageW-1:0]   frame,
  output logic [lru_tlb_pkg::CountW-1:0]  lookup_count,
  output logic [lru_tlb_pkg::CountW-1:0]  hit_count,
  output logic [lru_tlb_pkg::CountW-1:0]  eviction_count,
  output logic [lru_tlb_pkg::CountW-1:0]  flush_count,
  output logic [lru_tlb_pkg::CountW-1:0]  flush_drop_count
);

  logic              asid_enable;
  lru_tlb_pkg::cmd_t in_cmd;
  lru_tlb_pkg::cmd_t q_cmd;
  logic              q_valid;
  logic              q_ready;

  // configuration register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      asid_enable <= 1'b0;
    end else if (cfg_valid) begin
      asid_enable <= cfg_data;
    end
  end

  assign in_cmd.op     = lru_tlb_pkg::op_t'(operation);
  assign in_cmd.page   = virtual_page;
  assign in_cmd.space  = space_id;
  assign in_cmd.fframe = fill_frame;

  lru_tlb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .asid_on  (asid_enable),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  lru_tlb_back #(.ENTRIES(ENTRIES)) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_cmd            (q_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .hit              (hit),
    .frame            (frame),
    .lookup_count     (lookup_count),
    .hit_count        (hit_count),
    .eviction_count   (eviction_count),
    .flush_count      (flush_count),
    .flush_drop_count (flush_drop_count)
  );

  // a hit only ever comes with a counted hit
  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && hit |-> hit_count != $past(hit_count))
    else $error("hit without hit count advance");

  // a miss reports a zero frame
  a_miss_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> frame == '0)
    else $error("frame not zero on miss");

  // counters hold while a result beat waits
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(lookup_count) && $stable(flush_count))
    else $error("counters moved under a stalled result");

endmodule

>>> sim/tb_lru_tlb_with_asid.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lru_tlb_with_asid: self-checking bench for the LRU translation buffer
// Drives lookup, fill, flush and unused-code beats into the buffer. A
// behavioural copy of the entry array predicts each result beat, and every
// field is checked in order. Both channels idle and stall at random. The
// id compare switch is flipped between phases.
// ---------------------------------------------------------------------------
module tb_lru_tlb_with_asid;

  localparam int NumEntries = lru_tlb_pkg::DefaultEntries;
  localparam int PageW      = lru_tlb_pkg::PageW;
  localparam int SpaceW     = lru_tlb_pkg::SpaceW;
  localparam int CountW     = lru_tlb_pkg::CountW;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 12;

  typedef lru_tlb_pkg::op_t op_t;

  typedef struct packed {
    logic              hit;
    logic [PageW-1:0]  frame;
    logic [CountW-1:0] lookups;
    logic [CountW-1:0] hits;
    logic [CountW-1:0] evictions;
    logic [CountW-1:0] flushes;
    logic [CountW-1:0] drops;
  } xlat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = lru_tlb_pkg::OP_LOOKUP;
  logic [PageW-1:0] virtual_page = '0;
  logic [SpaceW-1:0] space_id = '0;
  logic [PageW-1:0] fill_frame = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [PageW-1:0] frame;
  logic [CountW-1:0] lookup_count, hit_count, eviction_count, flush_count;
  logic [CountW-1:0] flush_drop_count;

  lru_tlb_with_asid #(.ENTRIES(NumEntries)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .virtual_page(virtual_page),
    .space_id(space_id), .fill_frame(fill_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .frame(frame),
    .lookup_count(lookup_count), .hit_count(hit_count),
    .eviction_count(eviction_count), .flush_count(flush_count),
    .flush_drop_count(flush_drop_count)
  );

  // Shadow copy of the translation buffer
  bit                asid_on;
  bit                shadow_valid [NumEntries];
  logic [PageW-1:0]  shadow_page  [NumEntries];
  logic [PageW-1:0]  shadow_frame [NumEntries];
  logic [SpaceW-1:0] shadow_space [NumEntries];
  int unsigned       shadow_age   [NumEntries];
  logic [CountW-1:0] n_lookups, n_hits, n_evictions, n_flushes, n_drops;

  xlat_result_t pending_results [$];

  int  mismatches = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  cycles = 0;
  int  hold_off = 0;   // receiver stall, counted down in cycles
  bit  calm = 1'b0;    // no idling on either side while set
  int  op_seen [4];
  int  hits_seen = 0;

  // ---- clock, reset and watchdog -------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---- prediction -----------------------------------------------------------
  // Bring entry k to the front; valid entries younger than limit age by one.
  function automatic void promote(int k, int unsigned limit);
    for (int i = 0; i < NumEntries; i++)
      if (i != k && shadow_valid[i] && shadow_age[i] < limit) shadow_age[i]++;
    shadow_age[k] = 0;
  endfunction

  function automatic xlat_result_t translate(op_t op, logic [PageW-1:0] page,
                                             logic [SpaceW-1:0] sid,
                                             logic [PageW-1:0] fframe);
    xlat_result_t r;
    logic [SpaceW-1:0] eff_sid;
    int same, slot, oldest, k;
    int unsigned limit;
    r = '0;
    eff_sid = asid_on ? sid : '0;
    same = -1; slot = -1; oldest = -1;
    case (op)
      lru_tlb_pkg::OP_LOOKUP: begin
        n_lookups++;
        for (int i = 0; i < NumEntries; i++) begin
          if (!r.hit && shadow_valid[i] && shadow_page[i] == page &&
              shadow_space[i] == eff_sid) begin
            r.hit = 1'b1;
            r.frame = shadow_frame[i];
            n_hits++;
          end
        end
      end
      lru_tlb_pkg::OP_FILL: begin
        for (int i = 0; i < NumEntries; i++) begin
          if (shadow_valid[i]) begin
            if (same < 0 && shadow_page[i] == page) same = i;
            if (oldest < 0 || shadow_age[i] > shadow_age[oldest]) oldest = i;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (same >= 0) begin
          k = same;
          limit = shadow_age[k];
        end else if (slot >= 0) begin
          k = slot;
          limit = 32'hFF;
        end else begin
          k = (oldest >= 0) ? oldest : 0;
          limit = 32'hFF;
          n_evictions++;
        end
        shadow_valid[k] = 1'b1;
        shadow_page[k]  = page;
        shadow_frame[k] = fframe;
        shadow_space[k] = eff_sid;
        promote(k, limit);
      end
      lru_tlb_pkg::OP_FLUSH: begin
        for (int i = 0; i < NumEntries; i++) begin
          if (shadow_valid[i]) n_drops++;
          shadow_valid[i] = 1'b0;
          shadow_age[i] = 0;
        end
        n_flushes++;
      end
      default: ;  // unused code: state stays as it is
    endcase
    r.lookups = n_lookups;
    r.hits = n_hits;
    r.evictions = n_evictions;
    r.flushes = n_flushes;
    r.drops = n_drops;
    return r;
  endfunction

  // ---- sender ---------------------------------------------------------------
  // Called at a falling edge; returns at a falling edge once the beat is taken.
  task automatic send_beat(op_t op, logic [PageW-1:0] page,
                           logic [SpaceW-1:0] sid, logic [PageW-1:0] fframe);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    virtual_page = page;
    space_id = sid;
    fill_frame = fframe;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(translate(op, page, sid, fframe));
    op_seen[op]++;
    beats_in++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write the id switch while the buffer is idle.
  task automatic write_asid(bit value);
    wait_drained();
    repeat (DrainWait) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    asid_on = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---- receiver -------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (hold_off > 0) begin
      out_ready = 1'b0;
      hold_off--;
    end else if (calm) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(99) >= 35);
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    xlat_result_t want, got;
    if (!rst && out_valid && out_ready) begin
      got = '{hit, frame, lookup_count, hit_count, eviction_count,
              flush_count, flush_drop_count};
      beats_out++;
      if (hit) hits_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", beats_out);
            $display("  expected hit=%0d frame=%h counts=%0d/%0d/%0d/%0d/%0d",
                     want.hit, want.frame, want.lookups, want.hits,
                     want.evictions, want.flushes, want.drops);
            $display("  actual   hit=%0d frame=%h counts=%0d/%0d/%0d/%0d/%0d",
                     got.hit, got.frame, got.lookups, got.hits,
                     got.evictions, got.flushes, got.drops);
          end
        end
      end
    end
  end

  // ---- stimulus helpers -----------------------------------------------------
  function automatic logic [PageW-1:0] rand_page();
    return PageW'({$urandom(), $urandom()});
  endfunction

  // ---- tests ----------------------------------------------------------------
  // Extremes, every operation, eviction and in-place refill with ids ignored.
  task automatic test_directed();
    logic [PageW-1:0] ones;
    ones = '1;
    send_beat(lru_tlb_pkg::OP_LOOKUP, '0, '0, '0);      // miss on an empty buffer
    send_beat(lru_tlb_pkg::OP_FILL, '0, 8'hFF, ones);
    send_beat(lru_tlb_pkg::OP_FILL, ones, '0, '0);
    send_beat(lru_tlb_pkg::OP_LOOKUP, '0, 8'h5A, '0);   // id ignored: hits
    send_beat(lru_tlb_pkg::OP_LOOKUP, ones, 8'hFF, ones);
    send_beat(lru_tlb_pkg::OP_NONE, ones, 8'hFF, ones); // unused code
    send_beat(lru_tlb_pkg::OP_FLUSH, ones, 8'hFF, ones);
    send_beat(lru_tlb_pkg::OP_LOOKUP, '0, '0, '0);      // gone after the flush
    // fill beyond capacity so the oldest falls out
    for (int i = 0; i < NumEntries + 1; i++)
      send_beat(lru_tlb_pkg::OP_FILL, PageW'(i + 100), '0, PageW'(i) ^ ones);
    send_beat(lru_tlb_pkg::OP_FILL, PageW'(105), '0, PageW'(7)); // refill in place
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(100), '0, '0);     // evicted
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(105), '0, '0);
    send_beat(lru_tlb_pkg::OP_FLUSH, '0, '0, '0);               // full buffer dropped
  endtask

  // Ids compared: same page under other ids, in-place refill across ids.
  task automatic test_space_ids();
    write_asid(1'b1);
    send_beat(lru_tlb_pkg::OP_FILL, PageW'(42), 8'h01, PageW'(1));
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(42), 8'h02, '0);     // other id: miss
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(42), 8'h01, '0);
    send_beat(lru_tlb_pkg::OP_FILL, PageW'(42), 8'hFF, PageW'(2)); // same page, new id
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(42), 8'h01, '0);
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(42), 8'hFF, '0);
    write_asid(1'b0);
    send_beat(lru_tlb_pkg::OP_LOOKUP, PageW'(42), 8'hFF, '0);     // stored id is not zero
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits.
  task automatic test_back_pressure();
    wait_drained();
    @(negedge clk);
    hold_off = 80;
    for (int i = 0; i < 10; i++)
      send_beat(op_t'($urandom_range(1, 0)), PageW'($urandom_range(7)),
                SpaceW'($urandom_range(1)), rand_page());
    wait_drained();
  endtask

  // Mostly working-set traffic over a small page pool, with some noise.
  task automatic test_random(int count, bit asid_value);
    logic [PageW-1:0] pool [24];
    logic [SpaceW-1:0] sids [4];
    logic [PageW-1:0] page;
    logic [SpaceW-1:0] sid;
    int roll, span;
    op_t op;
    write_asid(asid_value);
    for (int i = 0; i < 24; i++) pool[i] = rand_page();
    for (int i = 0; i < 4; i++) sids[i] = SpaceW'($urandom());
    span = $urandom_range(23, 12);  // around the buffer size: hits and evictions
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 3 && n < count / 3 + 60);
      roll = $urandom_range(99);
      if (roll < 50) op = lru_tlb_pkg::OP_LOOKUP;
      else if (roll < 92) op = lru_tlb_pkg::OP_FILL;
      else if (roll < 96) op = lru_tlb_pkg::OP_FLUSH;
      else op = lru_tlb_pkg::OP_NONE;
      page = ($urandom_range(9) == 0) ? rand_page() : pool[$urandom_range(span)];
      sid = ($urandom_range(9) == 0) ? SpaceW'($urandom()) : sids[$urandom_range(3)];
      send_beat(op, page, sid, rand_page());
    end
    calm = 1'b0;
  endtask

  // ---- sequence -------------------------------------------------------------
  initial begin
    asid_on = 1'b0;
    n_lookups = '0; n_hits = '0; n_evictions = '0; n_flushes = '0; n_drops = '0;
    for (int i = 0; i < NumEntries; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_age[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed();
    test_space_ids();
    test_back_pressure();
    test_random(200, 1'b1);
    test_random(200, 1'b0);
    test_random(200, 1'b1);
    test_back_pressure();
    test_random(200, 1'b0);

    wait_drained();
    repeat (DrainWait) @(negedge clk);
    if (pending_results.size() != 0) mismatches += pending_results.size();

    $display("covered %0d beats (lookup %0d, fill %0d, flush %0d, unused %0d)",
             beats_in, op_seen[lru_tlb_pkg::OP_LOOKUP], op_seen[lru_tlb_pkg::OP_FILL],
             op_seen[lru_tlb_pkg::OP_FLUSH], op_seen[lru_tlb_pkg::OP_NONE]);
    $display("%0d results checked, %0d hits, %0d evictions, %0d mismatches",
             beats_out, hits_seen, n_evictions, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lru_tlb_pkg.sv
rtl/lru_tlb_front.sv
rtl/lru_tlb_back.sv
rtl/lru_tlb_with_asid.sv
sim/tb_lru_tlb_with_asid.sv
